@@ rtl/bfsp_pkg.sv @@
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared widths, request and result codes for the shortest paths unit.
// ----------------------------------------------------------------------------
package bfsp_pkg;

   // fixed field widths of the channels
   localparam int VERT_BITS   = 5;
   localparam int NV_BITS     = 6;
   localparam int IN_WT_BITS  = 16;
   localparam int DIST_BITS   = 32;
   localparam int KIND_BITS   = 2;
   localparam int REQ_BITS    = 2;

   // distance reported for a vertex the source cannot reach
   localparam logic [DIST_BITS-1:0] UNREACH_DIST = 32'd1000000;
   localparam logic [DIST_BITS-1:0] DIST_MAX     = 32'h7fff_ffff;
   localparam logic [DIST_BITS-1:0] DIST_MIN     = 32'h8000_0000;

   // request codes
   typedef enum logic [REQ_BITS-1:0] {
      REQ_LOAD  = 2'd0,
      REQ_RUN   = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   // result kinds
   typedef enum logic [KIND_BITS-1:0] {
      KIND_STATUS = 2'd0,
      KIND_VERTEX = 2'd1,
      KIND_CYCLE  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_code_type;

endpackage

@@ rtl/bfsp_if.sv @@
// ----------------------------------------------------------------------------
// bfsp interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfsp_req_if
   import bfsp_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic [REQ_BITS-1:0]          req_type;
   logic [VERT_BITS-1:0]         src_vertex;
   logic [VERT_BITS-1:0]         dst_vertex;
   logic signed [IN_WT_BITS-1:0] edge_weight;

   modport source (output valid, req_type, src_vertex, dst_vertex, edge_weight,
                   input ready);
   modport sink   (input valid, req_type, src_vertex, dst_vertex, edge_weight,
                   output ready);
endinterface

interface bfsp_rsp_if
   import bfsp_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic [KIND_BITS-1:0]        result_kind;
   logic [VERT_BITS-1:0]        vertex;
   logic signed [DIST_BITS-1:0] dist_value;
   logic                        reachable;
   logic [VERT_BITS-1:0]        pred_vertex;
   logic                        has_pred;
   logic                        neg_cycle;
   logic                        table_full;
   logic                        last;

   modport source (output valid, result_kind, vertex, dist_value, reachable,
                   pred_vertex, has_pred, neg_cycle, table_full, last,
                   input ready);
   modport sink   (input valid, result_kind, vertex, dist_value, reachable,
                   pred_vertex, has_pred, neg_cycle, table_full, last,
                   output ready);
endinterface

interface bfsp_csr_if
   import bfsp_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [NV_BITS-1:0] num_vertices;

   modport source (output valid, num_vertices, input ready);
   modport sink   (input valid, num_vertices, output ready);
endinterface

@@ rtl/bellman_ford_shortest_paths_unit.sv @@
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths_unit
// Single-source shortest paths with negative cycle detection over a stored
// edge table.
// ----------------------------------------------------------------------------
// Usage: req carries load edge, run and clear requests; rsp returns results
// with last marking the final one of each request; csr writes num_vertices
// (0 acts as 1, values above MAX_VERTICES act as MAX_VERTICES).
// A load or clear request answers with one status result the cycle after it
// is accepted. A run answers with one result per vertex and then, when a
// negative cycle is found, one result per cycle vertex.
// A run makes V passes over the edge table (V-1 plus a detection pass). Each
// pass visits every reachable tail in order: it fetches the tail's distance,
// then scans every stored edge and relaxes those the tail owns, so the run
// time is set by scanning the whole edge table for each tail.
// One request is worked on at a time; req.ready is low during a run and
// while a result waits on a stalled receiver. Results hold while rsp.ready
// is low. Synchronous reset empties the edge table, sets num_vertices to 32
// and drops any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_paths_unit
   import bfsp_pkg::*;
#(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES    = 256,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic       clock,
   input  logic       reset,
   bfsp_req_if.sink   req,
   bfsp_rsp_if.source rsp,
   bfsp_csr_if.sink   csr
);
   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int SW  = DIST_BITS + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, R_TAIL, R_TLAT, R_EREAD, R_ECHK, R_RELAX,
      T_BACK, T_BLAT, T_WALK, T_WLAT, V_RD, V_PUT, C_WRD, C_VRD, C_PUT
   } state_type;

   state_type               state_ff;
   logic [NV_BITS-1:0]      num_vertices_ff;
   logic [NV_BITS-1:0]      nv_use;
   logic [NV_BITS-1:0]      nv_ff;
   logic [VERT_BITS-1:0]    src_ff;
   logic [NV_BITS-1:0]      pass_ff;
   logic [NV_BITS-1:0]      u_ff;
   logic [ECW-1:0]          e_ff;
   logic [DIST_BITS-1:0]    dist_u_ff;
   logic [DIST_BITS-1:0]    cand_ff;
   logic [DIST_BITS-1:0]    cand_in;
   logic [VW-1:0]           h_ff;
   logic                    found_ff;
   logic [VW-1:0]           last_h_ff;
   logic [MAX_VERTICES-1:0] reach_ff;
   logic [MAX_VERTICES-1:0] pv_ff;
   logic [VW-1:0]           cur_ff;
   logic [VW-1:0]           start_ff;
   logic [NV_BITS-1:0]      i_ff;
   logic [NV_BITS-1:0]      len_ff;
   logic [NV_BITS-1:0]      ci_ff;
   logic [VW-1:0]           cv_ff;
   logic                    final_pass;
   logic                    relax_hit;
   logic                    req_fire;

   // response register
   logic                    rsp_valid_ff;
   logic [KIND_BITS-1:0]    rsp_kind_ff;
   logic [VERT_BITS-1:0]    rsp_vertex_ff;
   logic [DIST_BITS-1:0]    rsp_dist_ff;
   logic                    rsp_reach_ff;
   logic [VERT_BITS-1:0]    rsp_pred_ff;
   logic                    rsp_hasp_ff;
   logic                    rsp_neg_ff;
   logic                    rsp_full_ff;
   logic                    rsp_last_ff;
   logic                    rsp_free;
   logic                    rsp_set;

   // node memory: {pred, dist} per vertex
   logic [VW+DIST_BITS-1:0] node_mem [MAX_VERTICES];
   logic [VW+DIST_BITS-1:0] node_q_ff;
   logic                    node_rd_en;
   logic [VW-1:0]           node_rd_addr;
   logic                    node_wr_en;
   logic [VW-1:0]           node_wr_addr;
   logic [VW+DIST_BITS-1:0] node_wr_data;
   logic [DIST_BITS-1:0]    node_dist;
   logic [VW-1:0]           node_pred;

   // trace buffer of the cycle walk
   logic [VW-1:0]           walk_mem [MAX_VERTICES];
   logic [VW-1:0]           walk_q_ff;
   logic                    walk_wr_en;
   logic                    walk_rd_en;
   logic [NV_BITS-1:0]      walk_rd_idx;

   // edge table
   logic                    edge_load;
   logic                    edge_clear;
   logic                    edge_rd_en;
   logic [VERT_BITS-1:0]    edge_tail;
   logic [VERT_BITS-1:0]    edge_head;
   logic [WEIGHT_BITS-1:0]  edge_cost;
   logic [WEIGHT_BITS-1:0]  load_cost;
   logic [2*IN_WT_BITS-1:0] raw_weight;
   logic [ECW-1:0]          edge_count;
   logic                    edge_full;
   logic [SW-1:0]           sum;

   // vertex count clamp
   always_comb begin
      if (num_vertices_ff == '0) begin
         nv_use = NV_BITS'(1);
      end else if (num_vertices_ff > NV_BITS'(MAX_VERTICES)) begin
         nv_use = NV_BITS'(MAX_VERTICES);
      end else begin
         nv_use = num_vertices_ff;
      end
   end

   // register port
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         num_vertices_ff <= NV_BITS'(32);
      end else if (csr.valid) begin
         num_vertices_ff <= csr.num_vertices;
      end
   end

   // handshake
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && rsp_free;
   assign req_fire  = req.valid && req.ready;

   // a new result enters the response register
   assign rsp_set = (req_fire && ((req.req_type == REQ_LOAD) ||
                                  (req.req_type == REQ_CLEAR)))
                 || (((state_ff == V_PUT) || (state_ff == C_PUT)) && rsp_free);

   // edge table hookup; weight keeps its low WEIGHT_BITS bits
   assign raw_weight = {{IN_WT_BITS{1'b0}}, req.edge_weight};
   assign load_cost  = raw_weight[WEIGHT_BITS-1:0];
   assign edge_load  = req_fire && (req.req_type == REQ_LOAD);
   assign edge_clear = req_fire && (req.req_type == REQ_CLEAR);
   assign edge_rd_en = (state_ff == R_EREAD) && (e_ff != edge_count);

   bfsp_edge_store #(
      .MAX_EDGES   (MAX_EDGES),
      .WEIGHT_BITS (WEIGHT_BITS),
      .EIW         (EIW),
      .ECW         (ECW)
   ) u_edges (
      .clock      (clock),
      .reset      (reset),
      .load_en    (edge_load),
      .clear_en   (edge_clear),
      .wr_tail    (req.src_vertex),
      .wr_head    (req.dst_vertex),
      .wr_cost    (load_cost),
      .rd_en      (edge_rd_en),
      .rd_addr    (e_ff[EIW-1:0]),
      .rd_tail    (edge_tail),
      .rd_head    (edge_head),
      .rd_cost    (edge_cost),
      .edge_count (edge_count),
      .full       (edge_full)
   );

   // saturating candidate distance
   assign sum = {{2{dist_u_ff[DIST_BITS-1]}}, dist_u_ff}
              + {{(SW-WEIGHT_BITS){edge_cost[WEIGHT_BITS-1]}}, edge_cost};
   always_comb begin
      if (sum[DIST_BITS] != sum[DIST_BITS-1]) begin
         cand_in = sum[SW-1] ? DIST_MIN : DIST_MAX;
      end else begin
         cand_in = sum[DIST_BITS-1:0];
      end
   end

   assign node_dist  = node_q_ff[DIST_BITS-1:0];
   assign node_pred  = node_q_ff[VW+DIST_BITS-1:DIST_BITS];
   assign final_pass = (pass_ff == nv_ff - NV_BITS'(1));
   assign relax_hit  = !reach_ff[h_ff] || ($signed(cand_ff) < $signed(node_dist));

   // memory port control
   always_comb begin
      node_rd_en   = 1'b0;
      node_rd_addr = '0;
      node_wr_en   = 1'b0;
      node_wr_addr = h_ff;
      node_wr_data = {u_ff[VW-1:0], cand_ff};
      walk_wr_en   = 1'b0;
      walk_rd_en   = 1'b0;
      walk_rd_idx  = (ci_ff == '0) ? '0 : (len_ff - ci_ff);
      case (state_ff)
         S_INIT: begin
            node_wr_en   = ({1'b0, src_ff} < nv_ff);
            node_wr_addr = src_ff[VW-1:0];
            node_wr_data = '0;
         end
         R_TAIL: begin
            node_rd_en   = (u_ff != nv_ff);
            node_rd_addr = u_ff[VW-1:0];
         end
         R_ECHK: begin
            node_rd_en   = 1'b1;
            node_rd_addr = edge_head[VW-1:0];
         end
         R_RELAX: begin
            node_wr_en = relax_hit;
         end
         T_BACK, T_WALK: begin
            node_rd_en   = 1'b1;
            node_rd_addr = cur_ff;
            walk_wr_en   = (state_ff == T_WALK) && (len_ff < nv_ff) && pv_ff[cur_ff];
         end
         V_RD: begin
            node_rd_en   = 1'b1;
            node_rd_addr = i_ff[VW-1:0];
         end
         C_WRD: begin
            walk_rd_en = 1'b1;
         end
         C_VRD: begin
            node_rd_en   = 1'b1;
            node_rd_addr = walk_q_ff;
         end
         default: begin
         end
      endcase
   end

   // node memory
   always_ff @(posedge clock) begin
      if (node_wr_en) begin
         node_mem[node_wr_addr] <= node_wr_data;
      end
      if (node_rd_en) begin
         node_q_ff <= node_mem[node_rd_addr];
      end
   end

   // trace buffer
   always_ff @(posedge clock) begin
      if (walk_wr_en) begin
         walk_mem[len_ff[VW-1:0]] <= cur_ff;
      end
      if (walk_rd_en) begin
         walk_q_ff <= walk_mem[walk_rd_idx[VW-1:0]];
      end
   end

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         reach_ff     <= '0;
         pv_ff        <= '0;
         found_ff     <= 1'b0;
         len_ff       <= '0;
      end else begin
         if (rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  rsp_kind_ff   <= KIND_STATUS;
                  rsp_vertex_ff <= '0;
                  rsp_dist_ff   <= '0;
                  rsp_reach_ff  <= 1'b0;
                  rsp_pred_ff   <= '0;
                  rsp_hasp_ff   <= 1'b0;
                  rsp_neg_ff    <= 1'b0;
                  rsp_full_ff   <= (req.req_type == REQ_LOAD) && edge_full;
                  rsp_last_ff   <= 1'b1;
                  case (req.req_type)
                     REQ_RUN: begin
                        src_ff   <= req.src_vertex;
                        nv_ff    <= nv_use;
                        state_ff <= S_INIT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            // seed the source, clear the run state
            S_INIT: begin
               reach_ff <= ({1'b0, src_ff} < nv_ff) ?
                           (MAX_VERTICES'(1) << src_ff[VW-1:0]) : '0;
               pv_ff    <= '0;
               found_ff <= 1'b0;
               len_ff   <= '0;
               pass_ff  <= '0;
               u_ff     <= '0;
               state_ff <= R_TAIL;
            end
            // next tail vertex, or end of pass
            R_TAIL: begin
               if (u_ff == nv_ff) begin
                  u_ff <= '0;
                  i_ff <= '0;
                  if (!final_pass) begin
                     pass_ff <= pass_ff + NV_BITS'(1);
                  end else if (found_ff) begin
                     cur_ff   <= last_h_ff;
                     state_ff <= T_BACK;
                  end else begin
                     state_ff <= V_RD;
                  end
               end else if (reach_ff[u_ff[VW-1:0]] && (edge_count != '0)) begin
                  state_ff <= R_TLAT;
               end else begin
                  u_ff <= u_ff + NV_BITS'(1);
               end
            end
            R_TLAT: begin
               dist_u_ff <= node_dist;
               e_ff      <= '0;
               state_ff  <= R_EREAD;
            end
            R_EREAD: begin
               if (e_ff == edge_count) begin
                  u_ff     <= u_ff + NV_BITS'(1);
                  state_ff <= R_TAIL;
               end else begin
                  state_ff <= R_ECHK;
               end
            end
            // keep edges of this tail whose head is in range
            R_ECHK: begin
               if (({1'b0, edge_tail} == u_ff) && ({1'b0, edge_head} < nv_ff)) begin
                  cand_ff  <= cand_in;
                  h_ff     <= edge_head[VW-1:0];
                  state_ff <= R_RELAX;
               end else begin
                  e_ff     <= e_ff + ECW'(1);
                  state_ff <= R_EREAD;
               end
            end
            // an unreached head or a strict improvement relaxes; self loop updates the tail copy
            R_RELAX: begin
               if (relax_hit) begin
                  reach_ff[h_ff] <= 1'b1;
                  pv_ff[h_ff]    <= 1'b1;
                  if (h_ff == u_ff[VW-1:0]) begin
                     dist_u_ff <= cand_ff;
                  end
                  if (final_pass) begin
                     found_ff  <= 1'b1;
                     last_h_ff <= h_ff;
                  end
               end
               e_ff     <= e_ff + ECW'(1);
               state_ff <= R_EREAD;
            end
            // step back up to V predecessors to land inside the cycle
            T_BACK: begin
               if ((i_ff == nv_ff) || !pv_ff[cur_ff]) begin
                  start_ff <= cur_ff;
                  len_ff   <= '0;
                  state_ff <= T_WALK;
               end else begin
                  state_ff <= T_BLAT;
               end
            end
            T_BLAT: begin
               cur_ff   <= node_pred;
               i_ff     <= i_ff + NV_BITS'(1);
               state_ff <= T_BACK;
            end
            // walk the cycle into the trace buffer
            T_WALK: begin
               if ((len_ff >= nv_ff) || !pv_ff[cur_ff]) begin
                  len_ff   <= '0;
                  i_ff     <= '0;
                  state_ff <= V_RD;
               end else begin
                  len_ff   <= len_ff + NV_BITS'(1);
                  state_ff <= T_WLAT;
               end
            end
            T_WLAT: begin
               cur_ff <= node_pred;
               if (node_pred == start_ff) begin
                  i_ff     <= '0;
                  state_ff <= V_RD;
               end else begin
                  state_ff <= T_WALK;
               end
            end
            V_RD: begin
               state_ff <= V_PUT;
            end
            // per vertex result
            V_PUT: begin
               if (rsp_free) begin
                  rsp_kind_ff   <= KIND_VERTEX;
                  rsp_vertex_ff <= VERT_BITS'(i_ff);
                  rsp_dist_ff   <= reach_ff[i_ff[VW-1:0]] ? node_dist : UNREACH_DIST;
                  rsp_reach_ff  <= reach_ff[i_ff[VW-1:0]];
                  rsp_pred_ff   <= pv_ff[i_ff[VW-1:0]] ? VERT_BITS'(node_pred) : '0;
                  rsp_hasp_ff   <= pv_ff[i_ff[VW-1:0]];
                  rsp_neg_ff    <= found_ff;
                  rsp_full_ff   <= 1'b0;
                  rsp_last_ff   <= (i_ff == nv_ff - NV_BITS'(1)) && (len_ff == '0);
                  if (i_ff == nv_ff - NV_BITS'(1)) begin
                     ci_ff    <= '0;
                     state_ff <= (len_ff != '0) ? C_WRD : S_IDLE;
                  end else begin
                     i_ff     <= i_ff + NV_BITS'(1);
                     state_ff <= V_RD;
                  end
               end
            end
            C_WRD: begin
               state_ff <= C_VRD;
            end
            C_VRD: begin
               cv_ff    <= walk_q_ff;
               state_ff <= C_PUT;
            end
            // per cycle vertex result, in edge direction
            C_PUT: begin
               if (rsp_free) begin
                  rsp_kind_ff   <= KIND_CYCLE;
                  rsp_vertex_ff <= VERT_BITS'(cv_ff);
                  rsp_dist_ff   <= node_dist;
                  rsp_reach_ff  <= 1'b1;
                  rsp_pred_ff   <= VERT_BITS'(node_pred);
                  rsp_hasp_ff   <= pv_ff[cv_ff];
                  rsp_neg_ff    <= 1'b1;
                  rsp_full_ff   <= 1'b0;
                  rsp_last_ff   <= (ci_ff == len_ff - NV_BITS'(1));
                  if (ci_ff == len_ff - NV_BITS'(1)) begin
                     state_ff <= S_IDLE;
                  end else begin
                     ci_ff    <= ci_ff + NV_BITS'(1);
                     state_ff <= C_WRD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // response ports
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_kind = rsp_kind_ff;
   assign rsp.vertex      = rsp_vertex_ff;
   assign rsp.dist_value  = rsp_dist_ff;
   assign rsp.reachable   = rsp_reach_ff;
   assign rsp.pred_vertex = rsp_pred_ff;
   assign rsp.has_pred    = rsp_hasp_ff;
   assign rsp.neg_cycle   = rsp_neg_ff;
   assign rsp.table_full  = rsp_full_ff;
   assign rsp.last        = rsp_last_ff;

`ifndef SYNTHESIS
   // a vertex with a predecessor is always reachable
   a_pred_reach: assert property (@(posedge clock) disable iff (reset)
      (pv_ff & ~reach_ff) == '0)
      else $error("predecessor set on unreachable vertex");

   // the edge count stays within the table
   a_edge_count: assert property (@(posedge clock) disable iff (reset)
      edge_count <= ECW'(MAX_EDGES))
      else $error("edge count beyond table depth");

   // a relaxation marks its head reachable
   a_relax_reach: assert property (@(posedge clock) disable iff (reset)
      (state_ff == R_RELAX && relax_hit) |=> reach_ff[$past(h_ff)])
      else $error("relaxed head not reachable");

   // new results come only from idle or a put state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         ($past(state_ff) == S_IDLE || $past(state_ff) == V_PUT ||
          $past(state_ff) == C_PUT))
      else $error("result raised outside an output state");

   // the trace never holds more vertices than the run uses
   a_walk_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_WALK) |-> (len_ff <= nv_ff))
      else $error("cycle trace too long");
`endif

endmodule

@@ rtl/bfsp_edge_store.sv @@
// ----------------------------------------------------------------------------
// bfsp_edge_store
// Edge table memory with fill count; one write and one registered read.
// ----------------------------------------------------------------------------
module bfsp_edge_store
   import bfsp_pkg::*;
#(
   parameter int MAX_EDGES   = 256,
   parameter int WEIGHT_BITS = 16,
   parameter int EIW         = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
   parameter int ECW         = $clog2(MAX_EDGES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_en,
   input  logic                   clear_en,
   input  logic [VERT_BITS-1:0]   wr_tail,
   input  logic [VERT_BITS-1:0]   wr_head,
   input  logic [WEIGHT_BITS-1:0] wr_cost,
   input  logic                   rd_en,
   input  logic [EIW-1:0]         rd_addr,
   output logic [VERT_BITS-1:0]   rd_tail,
   output logic [VERT_BITS-1:0]   rd_head,
   output logic [WEIGHT_BITS-1:0] rd_cost,
   output logic [ECW-1:0]         edge_count,
   output logic                   full
);
   localparam int EW = 2 * VERT_BITS + WEIGHT_BITS;

   logic [EW-1:0]  edge_mem [MAX_EDGES];
   logic [EW-1:0]  rd_data_ff;
   logic [ECW-1:0] count_ff;
   logic           store_en;

   assign full     = (count_ff == ECW'(MAX_EDGES));
   assign store_en = load_en && !full;

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (clear_en) begin
         count_ff <= '0;
      end else if (store_en) begin
         count_ff <= count_ff + ECW'(1);
      end
   end

   // edge memory
   always_ff @(posedge clock) begin
      if (store_en) begin
         edge_mem[count_ff[EIW-1:0]] <= {wr_tail, wr_head, wr_cost};
      end
      if (rd_en) begin
         rd_data_ff <= edge_mem[rd_addr];
      end
   end

   assign rd_tail    = rd_data_ff[EW-1 -: VERT_BITS];
   assign rd_head    = rd_data_ff[WEIGHT_BITS +: VERT_BITS];
   assign rd_cost    = rd_data_ff[WEIGHT_BITS-1:0];
   assign edge_count = count_ff;

endmodule
